FILE: rtl/bsag_pkg.sv
package bsag_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int STABLE_COUNT = 10;
  localparam int FW           = FRAC_BITS + 16;

  localparam logic [15:0] MIN_DI_CA = 16'd200;
  localparam logic [15:0] MIN_DV_CV = 16'd40;
  localparam logic [31:0] RC_IMP_STABLE_US = 32'd1200000;
  localparam logic [31:0] RC_IMP_LEARN_US  = 32'd500000;
  localparam logic [31:0] RC_SAG_FALL_US   = 32'd40000000;
  localparam logic [31:0] RC_SAG_RISE_US   = 32'd500000000;
  localparam logic [9:0]  WEIGHT_RESET     = 10'd256;

  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP_1000  = 32'd2199023256;
  localparam int          RECIP_SHIFT = 41;

  localparam int DIV_W = 64;

  typedef struct packed {
    logic [15:0] voltage_cv;
    logic [15:0] current_ca;
    logic [15:0] full_voltage_cv;
    logic [15:0] delta_time_us;
    logic        sample_tick;
  } bsag_in_t;

  typedef struct packed {
    logic [15:0]        compensated_cv;
    logic [15:0]        impedance_mohm;
    logic signed [15:0] factor_q12;
    logic               div_fault;
  } bsag_out_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } bsag_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } bsag_div_rsp_t;

endpackage

FILE: rtl/bsag_div.sv
module bsag_div
  import bsag_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  bsag_div_req_t req,
  output bsag_div_rsp_t rsp
);

  logic [DIV_W-1:0]         q_r, q_nxt;
  logic [DIV_W-1:0]         rem_r, rem_nxt;
  logic [DIV_W-1:0]         den_r, den_nxt;
  logic [$clog2(DIV_W):0]   cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [DIV_W:0]           trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (req.start) begin
      q_nxt    = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r, q_r[DIV_W-1]} - {1'b0, den_r};
      if (!trial[DIV_W]) begin
        rem_nxt = trial[DIV_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DIV_W-2:0], q_r[DIV_W-1]};
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ($clog2(DIV_W)+1)'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

FILE: rtl/battery_sag_throttle_compensation.sv
// Battery sag compensation: each beat takes one measurement and returns one result beat
// with the compensated voltage, published impedance and a Q4.12 throttle factor. The
// impedance quotient, both filter steps and the factor share one restoring divider, and
// the sequencer waits on each quotient in turn. The load drop over 1000 uses a reciprocal
// multiply. An unknown full voltage skips all impedance and sag filter steps, a beat
// without an impedance sample skips the impedance quotient, and a sample that loads an
// empty filter skips the impedance filter step; a zero compensated voltage skips the
// factor quotient. in_stall is high from acceptance until the result is presented,
// and longer while that result waits behind an earlier one still held by out_stall.
module battery_sag_throttle_compensation
  import bsag_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  bsag_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output bsag_out_t out_data,
  input  logic      cfg_we,
  input  logic [9:0] cfg_data
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_PREP  = 11'b00000000010,
    ST_ZDIV  = 11'b00000000100,
    ST_IMPF  = 11'b00000001000,
    ST_IMPW  = 11'b00000010000,
    ST_SAGD  = 11'b00000100000,
    ST_SAGM  = 11'b00001000000,
    ST_SAGF  = 11'b00010000000,
    ST_SAGW  = 11'b00100000000,
    ST_FACD  = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_t;

  state_t st_r, st_prev_r;

  logic [9:0]  weight_r;
  logic [15:0] prev_v_r, prev_i_r;
  logic [3:0]  cnt_r;
  logic [FW-1:0] imp_f_r, sag_f_r;
  logic [15:0] pub_r, comp_r;
  bsag_in_t    it_r;
  bsag_out_t   res_r;
  logic        outv_r;
  logic        neg_r;
  logic [FW-1:0] samp_r;
  logic [31:0] rc_r;
  logic [31:0] zi_r;
  logic [63-RECIP_SHIFT:0] kq_r;
  logic signed [15:0] fac_r;
  logic        flt_r;

  bsag_div_req_t dreq;
  bsag_div_rsp_t drsp;

  bsag_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic signed [16:0] di, dv;
  logic        take;
  logic [15:0] z_sat;
  logic [3:0]  cnt_inc;
  logic [63:0] kprod;
  logic [23:0] sag_sum;
  logic [15:0] sag_cl;
  logic [FW-1:0] sagq;
  logic signed [17:0] fdiff;
  logic [16:0] fmag;
  logic [31:0] fnum;
  logic signed [31:0] fac;
  logic [FW-1:0] cur_f;
  logic [FW-1:0] new_f;
  logic [FW-1:0] absd;

  function automatic logic [15:0] to_sat(input logic [FW-1:0] q);
    logic [FW:0] r;
    r = ({1'b0, q} + (FW+1)'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
    to_sat = (r > (FW+1)'(65535)) ? 16'hFFFF : r[15:0];
  endfunction

  assign di = $signed({1'b0, it_r.current_ca}) - $signed({1'b0, prev_i_r});
  assign dv = $signed({1'b0, prev_v_r}) - $signed({1'b0, it_r.voltage_cv});
  assign take = !it_r.sample_tick && (di >= $signed({1'b0, MIN_DI_CA}))
                && (dv >= $signed({1'b0, MIN_DV_CV}));
  assign z_sat = (drsp.quot > 64'd65535) ? 16'hFFFF : drsp.quot[15:0];
  assign cnt_inc = (cnt_r <= 4'(STABLE_COUNT)) ? cnt_r + 4'd1 : cnt_r;

  assign kprod   = zi_r * RECIP_1000;
  assign sag_sum = 24'(it_r.voltage_cv) + 24'(kq_r);
  assign sag_cl  = (sag_sum > 24'(it_r.full_voltage_cv)) ? it_r.full_voltage_cv
                                                         : sag_sum[15:0];
  assign sagq    = FW'(sag_cl) << FRAC_BITS;

  assign fdiff = $signed({2'b0, it_r.full_voltage_cv}) - $signed({2'b0, comp_r});
  assign fmag  = fdiff[17] ? 17'(-fdiff) : 17'(fdiff);
  assign fnum  = 32'(fmag) * 32'(weight_r) * 32'd16;
  assign fac   = 32'sd4096 + (fdiff[17] ? -$signed({1'b0, drsp.quot[30:0]})
                                        : $signed({1'b0, drsp.quot[30:0]}));

  assign cur_f = st_r == ST_IMPW ? imp_f_r : sag_f_r;
  assign new_f = neg_r ? cur_f - drsp.quot[FW-1:0] : cur_f + drsp.quot[FW-1:0];
  assign absd  = neg_r ? cur_f - samp_r : samp_r - cur_f;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      weight_r <= WEIGHT_RESET;
      prev_v_r <= '0;
      prev_i_r <= '0;
      cnt_r    <= '0;
      imp_f_r  <= '0;
      sag_f_r  <= '0;
      pub_r    <= '0;
      comp_r   <= '0;
      outv_r   <= 1'b0;
    end else begin
      if (cfg_we) weight_r <= cfg_data;
      if (outv_r && !out_stall) outv_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            it_r <= in_data;
            st_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (it_r.full_voltage_cv == '0) begin
            sag_f_r <= FW'(it_r.voltage_cv) << FRAC_BITS;
            comp_r  <= it_r.voltage_cv;
            imp_f_r <= '0;
            st_r    <= ST_FACD;
          end else if (it_r.sample_tick) begin
            prev_i_r <= it_r.current_ca;
            prev_v_r <= it_r.voltage_cv;
            st_r     <= ST_SAGD;
          end else if (take) begin
            st_r <= ST_ZDIV;
          end else begin
            st_r <= ST_SAGD;
          end
        end
        ST_ZDIV: begin
          if (drsp.done) begin
            cnt_r <= cnt_inc;
            if (imp_f_r == '0) begin
              imp_f_r <= FW'(z_sat) << FRAC_BITS;
              if (cnt_inc > 4'(STABLE_COUNT)) pub_r <= to_sat(FW'(z_sat) << FRAC_BITS);
              st_r <= ST_SAGD;
            end else begin
              samp_r <= FW'(z_sat) << FRAC_BITS;
              rc_r   <= (cnt_inc > 4'(STABLE_COUNT)) ? RC_IMP_STABLE_US : RC_IMP_LEARN_US;
              st_r   <= ST_IMPF;
            end
          end
        end
        ST_IMPF: begin
          neg_r <= samp_r < imp_f_r;
          st_r  <= ST_IMPW;
        end
        ST_IMPW: begin
          if (drsp.done) begin
            imp_f_r <= new_f;
            if (cnt_r > 4'(STABLE_COUNT)) pub_r <= to_sat(new_f);
            st_r <= ST_SAGD;
          end
        end
        ST_SAGD: begin
          zi_r <= 32'(pub_r) * 32'(it_r.current_ca);
          st_r <= ST_SAGM;
        end
        ST_SAGM: begin
          kq_r <= kprod[63:RECIP_SHIFT];
          st_r <= ST_SAGF;
        end
        ST_SAGF: begin
          samp_r <= sagq;
          rc_r   <= (sagq < sag_f_r) ? RC_SAG_FALL_US : RC_SAG_RISE_US;
          neg_r  <= sagq < sag_f_r;
          st_r   <= ST_SAGW;
        end
        ST_SAGW: begin
          if (drsp.done) begin
            sag_f_r <= new_f;
            comp_r  <= to_sat(new_f);
            st_r    <= ST_FACD;
          end
        end
        ST_FACD: begin
          if (comp_r == '0) begin
            flt_r <= 1'b1;
            if (weight_r == '0) fac_r <= 16'sd4096;
            else if (it_r.full_voltage_cv == '0)
              fac_r <= 16'(32'sd4096 - 32'(weight_r) * 32'sd16);
            else fac_r <= 16'sd32767;
            st_r <= ST_OUT;
          end else if (drsp.done) begin
            flt_r <= 1'b0;
            if (fac > 32'sd32767) fac_r <= 16'sd32767;
            else if (fac < -32'sd32768) fac_r <= -16'sd32768;
            else fac_r <= fac[15:0];
            st_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!outv_r) begin
            res_r.compensated_cv <= comp_r;
            res_r.impedance_mohm <= pub_r;
            res_r.factor_q12     <= fac_r;
            res_r.div_fault      <= flt_r;
            outv_r <= 1'b1;
            st_r   <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // divider requests, issued on entry to each waiting state (ST_FACD only when comp_r is nonzero)
  always_ff @(posedge clk) begin
    if (!rst_n) st_prev_r <= ST_IDLE;
    else st_prev_r <= st_r;
  end

  always_comb begin
    dreq = '0;
    if (st_r != st_prev_r) begin
      unique case (st_r)
        ST_ZDIV: begin
          dreq.start = 1'b1;
          dreq.num   = 64'(dv) * 64'd1000;
          dreq.den   = 64'(di);
        end
        ST_IMPW, ST_SAGW: begin
          dreq.start = 1'b1;
          dreq.num   = 64'(absd) * 64'(it_r.delta_time_us);
          dreq.den   = 64'(rc_r) + 64'(it_r.delta_time_us);
        end
        ST_FACD: begin
          dreq.start = comp_r != '0;
          dreq.num   = 64'(fnum);
          dreq.den   = 64'(comp_r);
        end
        default: dreq = '0;
      endcase
    end
  end

  assign in_stall  = st_r != ST_IDLE;
  assign out_valid = outv_r;
  assign out_data  = res_r;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bsag_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int RANDOM_ITEMS = 1650;
  localparam int SETTLE = 400;

  typedef struct {
    bsag_in_t  meas;
    bit        typed;
    bsag_out_t want;
  } dir_row_t;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  bsag_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  bsag_out_t out_data;
  logic      cfg_we = 0;
  logic [9:0] cfg_data = '0;

  battery_sag_throttle_compensation uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  longint weight_q8, last_v, last_i, zs_count, z_filt, sag_filt, z_pub, vcomp;

  bsag_out_t expected_beats[$];
  dir_row_t  dir_tab[$];
  int errors = 0, beats_checked = 0, cycles = 0, items_sent = 0, published_seen = 0;
  bit quiet = 0;

  // random sequence state
  int seq_left = 0;
  longint seq_v, seq_i, seq_full;

  function automatic longint smooth(longint st, longint x, longint dt, longint rc);
    longint d;
    d = x - st;
    return st + d * dt / (rc + dt);
  endfunction

  function automatic longint q_to_cv(longint q);
    longint r;
    r = (q + (64'd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    return r > 65535 ? 65535 : r;
  endfunction

  function automatic bsag_out_t predict_sag(bsag_in_t m);
    longint v, c, f, dt, di, dv, z, sag, sq, fac;
    bsag_out_t r;
    v = m.voltage_cv; c = m.current_ca; f = m.full_voltage_cv; dt = m.delta_time_us;
    r = '0;
    if (f == 0) begin
      sag_filt = v << FRAC_BITS;
      vcomp = v;
      z_filt = 0;
    end else begin
      if (m.sample_tick) begin
        last_i = c;
        last_v = v;
      end else begin
        di = c - last_i;
        dv = last_v - v;
        if (di >= longint'(MIN_DI_CA) && dv >= longint'(MIN_DV_CV)) begin
          z = dv * 1000 / di;
          if (z > 65535) z = 65535;
          if (zs_count <= STABLE_COUNT) zs_count = zs_count + 1;
          if (z_filt != 0)
            z_filt = smooth(z_filt, z << FRAC_BITS, dt, zs_count > STABLE_COUNT ?
                            longint'(RC_IMP_STABLE_US) : longint'(RC_IMP_LEARN_US));
          else
            z_filt = z << FRAC_BITS;
          if (zs_count > STABLE_COUNT) z_pub = q_to_cv(z_filt);
        end
      end
      sag = v + z_pub * c / 1000;
      if (sag > f) sag = f;
      sq = sag << FRAC_BITS;
      sag_filt = smooth(sag_filt, sq, dt, sq < sag_filt ?
                        longint'(RC_SAG_FALL_US) : longint'(RC_SAG_RISE_US));
      vcomp = q_to_cv(sag_filt);
    end
    if (vcomp == 0) begin
      r.div_fault = 1'b1;
      if (weight_q8 == 0) fac = 4096;
      else if (f == 0) fac = 4096 - 16 * weight_q8;
      else fac = 32767;
    end else begin
      fac = 4096 + (f - vcomp) * 16 * weight_q8 / vcomp;
    end
    if (fac > 32767) fac = 32767;
    if (fac < -32768) fac = -32768;
    r.compensated_cv = vcomp[15:0];
    r.impedance_mohm = z_pub[15:0];
    r.factor_q12 = fac[15:0];
    return r;
  endfunction

  task automatic add_row(input int v, c, f, dt, t, input bit typed = 0,
                         input bsag_out_t want = '0);
    dir_row_t row;
    row.meas.voltage_cv = 16'(v);
    row.meas.current_ca = 16'(c);
    row.meas.full_voltage_cv = 16'(f);
    row.meas.delta_time_us = 16'(dt);
    row.meas.sample_tick = 1'(t);
    row.typed = typed;
    row.want = want;
    dir_tab.push_back(row);
  endtask

  task automatic next_random(output bsag_in_t m);
    m.voltage_cv = 16'($urandom);
    m.current_ca = 16'($urandom);
    m.full_voltage_cv = 16'($urandom);
    m.delta_time_us = 16'($urandom);
    m.sample_tick = 1'($urandom);
    if (seq_left == 0) begin
      if ($urandom_range(99) < 25) begin
        if ($urandom_range(7) == 0) m.full_voltage_cv = '0;
        if ($urandom_range(15) == 0) m.delta_time_us = '0;
        return;
      end
      seq_v = $urandom_range(900, 5000);
      seq_i = $urandom_range(0, 3000);
      seq_full = seq_v + $urandom_range(0, 800);
      seq_left = $urandom_range(2, 8);
      m.voltage_cv = 16'(seq_v);
      m.current_ca = 16'(seq_i);
      m.sample_tick = 1'b1;
    end else begin
      seq_left--;
      m.voltage_cv = 16'(seq_v - $urandom_range(20, 600));
      m.current_ca = 16'(seq_i + $urandom_range(150, 5000));
      m.sample_tick = 1'b0;
    end
    m.full_voltage_cv = 16'(seq_full);
    m.delta_time_us = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(500, 2000));
  endtask

  task automatic send_beat(input bsag_in_t m, input bit typed, input bsag_out_t want);
    bsag_out_t p;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 14) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_data = m;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    p = predict_sag(m);
    expected_beats.push_back(typed ? want : p);
    items_sent++;
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain_and_write(input logic [9:0] w);
    wait (expected_beats.size() == 0);
    repeat (SETTLE) @(negedge clk);
    cfg_we = 1;
    cfg_data = w;
    weight_q8 = w;
    @(negedge clk);
    cfg_we = 0;
  endtask

  always @(negedge clk) out_stall <= !quiet && ($urandom_range(99) < 14);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        bsag_out_t e;
        e = expected_beats.pop_front();
        beats_checked++;
        if (out_data.impedance_mohm != 0) published_seen++;
        if (out_data.compensated_cv != e.compensated_cv ||
            out_data.impedance_mohm != e.impedance_mohm ||
            out_data.factor_q12 != e.factor_q12 ||
            out_data.div_fault != e.div_fault) begin
          errors++;
          if (errors <= 10)
            $display("beat %0d mismatch: want v=%0d z=%0d f=%0d d=%0b got v=%0d z=%0d f=%0d d=%0b",
                     beats_checked, e.compensated_cv, e.impedance_mohm, e.factor_q12,
                     e.div_fault, out_data.compensated_cv, out_data.impedance_mohm,
                     out_data.factor_q12, out_data.div_fault);
        end
      end
    end
  end

  initial begin
    bsag_in_t m;
    bsag_out_t w;
    logic [9:0] weights [6];
    weights = '{10'd0, 10'd512, 10'd1023, 10'd1, 10'd100, 10'd256};
    weight_q8 = WEIGHT_RESET;
    last_v = 0; last_i = 0; zs_count = 0; z_filt = 0; sag_filt = 0; z_pub = 0; vcomp = 0;

    w = '{compensated_cv: 0, impedance_mohm: 0, factor_q12: 0, div_fault: 1};
    add_row(0, 0, 0, 1, 0, 1, w);
    w = '{compensated_cv: 65535, impedance_mohm: 0, factor_q12: 0, div_fault: 0};
    add_row(65535, 65535, 0, 65535, 1, 1, w);
    add_row(65535, 0, 65535, 65535, 1);
    add_row(0, 200, 65535, 1, 0);
    add_row(1200, 100, 1260, 1000, 1);
    for (int k = 0; k < 11; k++) add_row(1100, 1500, 1260, k == 0 ? 65535 : 1000 + k, 0);
    add_row(1100, 65535, 1260, 0, 0);
    add_row(1100, 1500, 0, 1000, 0);
    add_row(1100, 1500, 1260, 1000, 0);
    add_row(1, 0, 65535, 1, 0);
    add_row(65535, 65535, 65535, 65535, 0);

    repeat (5) @(negedge clk);
    rst_n = 1;

    foreach (dir_tab[k]) send_beat(dir_tab[k].meas, dir_tab[k].typed, dir_tab[k].want);

    for (int ph = 0; ph < 6; ph++) begin
      drain_and_write(weights[ph]);
      quiet = (ph == 2);
      for (int k = 0; k < RANDOM_ITEMS / 6; k++) begin
        if (k == 100) wait (expected_beats.size() == 0);
        next_random(m);
        send_beat(m, 0, '0);
      end
      quiet = 0;
    end

    wait (expected_beats.size() == 0);
    repeat (SETTLE) @(posedge clk);
    $display("%0d measurements sent, %0d result beats checked over six gain settings",
             items_sent, beats_checked);
    $display("%0d beats carried a published impedance, %0d errors", published_seen, errors);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
